// File: hw/rtl/flptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker package
// Shared constants and a helper function for the four-level page table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

   localparam int TABLE_PAGES_DEF = 64;
   localparam int PA_W            = 52;
   localparam int VA_W            = 48;

   localparam logic [2:0] ACT_MAP      = 3'd0;
   localparam logic [2:0] ACT_UNMAP    = 3'd1;
   localparam logic [2:0] ACT_XLATE    = 3'd2;
   localparam logic [2:0] ACT_ACTIVATE = 3'd3;
   localparam logic [2:0] ACT_ALLOC    = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MAPPED    = 3'd1;
   localparam logic [2:0] ST_NOTMAPPED = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_OUTSIDE   = 3'd4;

   localparam logic CSR_PA_BITS = 1'b0;
   localparam logic CSR_BASE    = 1'b1;

   localparam logic [63:0] E_PRESENT = 64'h1;
   localparam logic [63:0] E_WRITE   = 64'h2;
   localparam logic [63:0] E_USER    = 64'h4;
   localparam logic [63:0] E_NX      = 64'h8000_0000_0000_0000;

   // Entry address mask for a given physical address width.
   function automatic logic [PA_W-1:0] addr_mask(input logic [5:0] bits);
      logic [5:0]      b;
      logic [PA_W-1:0] m;
      b = (bits > 6'd52) ? 6'd52 : bits;
      m = '0;
      for (int i = 12; i < PA_W; i++) m[i] = (i < int'(b));
      return m;
   endfunction

endpackage

// File: hw/rtl/flptw_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table store
// Single-port synchronous entry memory with registered read data.
// ----------------------------------------------------------------------------
module flptw_store #(
   parameter int AW = 15
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [63:0]   wdata,
   output logic [63:0]   rdata
);
   logic [63:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// File: hw/rtl/four_level_page_table_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker
// Walks, allocates and edits x86-64 style page tables kept in an internal store.
// ----------------------------------------------------------------------------
// Activate, allocate and unused actions go from idle straight to the response state.
// Map, unmap and translate run check, read and evaluate states on each of the four
// levels before the response state; an outside or full walk stops early. One item at
// a time; busy is high from transfer to response, a new transfer may land in the
// response cycle. Reset starts a clearing pass over every store entry, busy high.
// No receiver stall.
module four_level_page_table_walker_top #(
   parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_action,
   input  logic [flptw_pkg::PA_W-1:0]    req_root_addr,
   input  logic [flptw_pkg::VA_W-1:0]    req_virt_addr,
   input  logic [flptw_pkg::PA_W-1:0]    req_phys_page_addr,
   input  logic                          req_flag_write,
   input  logic                          req_flag_exec,
   input  logic                          req_flag_user,
   input  logic                          req_free_page,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [flptw_pkg::PA_W-1:0]    rsp_phys_result,
   output logic [flptw_pkg::PA_W-1:0]    rsp_freed_addr,
   output logic                          rsp_freed_valid,
   output logic                          rsp_invalidate,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [flptw_pkg::PA_W-1:0]    csr_wdata
);
   import flptw_pkg::*;

   localparam int PW = $clog2(TABLE_PAGES);
   localparam int AW = PW + 9;
   localparam int CW = $clog2(TABLE_PAGES + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_LEAF  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [5:0]      pab_ff;
   logic [PA_W-1:0] base_ff, active_ff;
   logic [CW-1:0]   nft_ff, nft_in;
   logic [2:0]      act_ff;
   logic [PA_W-1:0] root_ff, pa_ff;
   logic [VA_W-1:0] va_ff;
   logic [3:0]      flg_ff;
   logic [1:0]      lvl_ff, lvl_in;
   logic [PA_W-1:0] t_ff, t_in;
   logic [PW-1:0]   page_ff, page_in;
   logic            rv_ff, rv_in;
   logic [2:0]      st_ff, st_in;
   logic [PA_W-1:0] res_ff, res_in, fa_ff, fa_in;
   logic            fv_ff, fv_in, inv_ff, inv_in;

   logic            we;
   logic [AW-1:0]   addr;
   logic [63:0]     wdata, rdata;

   flptw_store #(.AW(AW)) u_store (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   logic [PA_W-1:0] mask, base, diff, new_addr;
   logic            in_store;
   logic [8:0]      idx;
   logic            active;

   always_comb begin
      mask     = addr_mask(pab_ff);
      base     = {base_ff[PA_W-1:12], 12'h000};
      diff     = t_ff - base;
      in_store = (t_ff >= base) && ({{(PA_W-40){1'b0}}, diff[PA_W-1:12]} <
                 PA_W'(nft_ff));
      new_addr = base + {{(PA_W-12-CW){1'b0}}, nft_ff, 12'h000};
      active   = ((root_ff & mask) == (active_ff & mask));
      unique case (lvl_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      nft_in   = nft_ff;
      lvl_in   = lvl_ff;
      t_in     = t_ff;
      page_in  = page_ff;
      rv_in    = 1'b0;
      st_in    = st_ff;
      res_in   = res_ff;
      fa_in    = fa_ff;
      fv_in    = fv_ff;
      inv_in   = inv_ff;
      we       = 1'b0;
      addr     = {page_ff, idx};
      wdata    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            addr  = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               st_in  = ST_OK;
               res_in = '0;
               fa_in  = '0;
               fv_in  = 1'b0;
               inv_in = 1'b0;
               lvl_in = 2'd0;
               t_in   = req_root_addr & mask;
               state_in = S_DONE;
               case (req_action)
                  ACT_MAP, ACT_UNMAP, ACT_XLATE: state_in = S_CHECK;
                  ACT_ALLOC: begin
                     if (nft_ff >= CW'(TABLE_PAGES)) st_in = ST_FULL;
                     else begin
                        res_in = base + {{(PA_W-12-CW){1'b0}}, nft_ff, 12'h000};
                        nft_in = nft_ff + CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (!in_store) begin
               st_in = ST_OUTSIDE;
               state_in = S_DONE;
            end else begin
               page_in  = diff[12 +: PW];
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EVAL;   // address issued, data next cycle
         S_EVAL: begin
            if (lvl_ff != 2'd3) begin
               if (rdata[0]) begin
                  t_in = rdata[PA_W-1:0] & mask;
                  lvl_in = lvl_ff + 2'd1;
                  state_in = S_CHECK;
               end else if (nft_ff >= CW'(TABLE_PAGES)) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  we     = 1'b1;
                  wdata  = {12'h000, new_addr} | E_PRESENT | E_WRITE | E_USER;
                  nft_in = nft_ff + CW'(1);
                  t_in   = new_addr & mask;
                  lvl_in = lvl_ff + 2'd1;
                  state_in = S_CHECK;
               end
            end else begin
               state_in = S_DONE;
               case (act_ff)
                  ACT_MAP: begin
                     if (rdata != '0) st_in = ST_MAPPED;
                     else begin
                        we    = 1'b1;
                        wdata = {12'h000, pa_ff & mask} | E_PRESENT
                              | (flg_ff[0] ? E_WRITE : 64'h0)
                              | (flg_ff[1] ? 64'h0 : E_NX)
                              | (flg_ff[2] ? E_USER : 64'h0);
                        inv_in = active;
                     end
                  end
                  ACT_UNMAP: begin
                     if (!rdata[0]) st_in = ST_NOTMAPPED;
                     else begin
                        we = 1'b1;
                        if (flg_ff[3]) begin
                           fa_in = rdata[PA_W-1:0] & mask;
                           fv_in = 1'b1;
                        end
                        inv_in = active;
                     end
                  end
                  default: begin
                     if (rdata[0]) res_in = (rdata[PA_W-1:0] & mask) |
                                            {40'h0, va_ff[11:0]};
                     else st_in = ST_NOTMAPPED;
                  end
               endcase
            end
         end
         S_LEAF: state_in = S_DONE;
         S_DONE: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         nft_ff    <= '0;
         active_ff <= '0;
         pab_ff    <= 6'd52;
         base_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         nft_ff   <= nft_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            if (csr_index == CSR_PA_BITS) pab_ff <= csr_wdata[5:0];
            else base_ff <= csr_wdata;
         end
         if (state_ff == S_IDLE && start && req_action == ACT_ACTIVATE)
            active_ff <= req_root_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         act_ff  <= req_action;
         root_ff <= req_root_addr;
         va_ff   <= req_virt_addr;
         pa_ff   <= req_phys_page_addr;
         flg_ff  <= {req_free_page, req_flag_user, req_flag_exec, req_flag_write};
      end
      lvl_ff  <= lvl_in;
      t_ff    <= t_in;
      page_ff <= page_in;
      st_ff   <= st_in;
      res_ff  <= res_in;
      fa_ff   <= fa_in;
      fv_ff   <= fv_in;
      inv_ff  <= inv_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_phys_result = res_ff;
   assign rsp_freed_addr  = fa_ff;
   assign rsp_freed_valid = fv_ff;
   assign rsp_invalidate  = inv_ff;

   a_nft_bound: assert property (@(posedge clock) disable iff (reset)
      nft_ff <= CW'(TABLE_PAGES)) else $error("allocator overran store");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rv_ff |=> !rv_ff) else $error("double response");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rv_ff) else $error("missing response");
endmodule
